// ===== hw/rtl/xr128_pkg.sv =====
// Shared types, constants and mixing function for the xorshift128 generator.
package xr128_pkg;

    typedef logic [3:0][31:0] words_t;

    typedef enum logic [1:0] {
        CMD_DRAW32 = 2'd0,
        CMD_DRAW64 = 2'd1,
        CMD_SEED   = 2'd2,
        CMD_LOAD   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

    localparam logic [31:0] MULT_K = 32'h6C07_8965;

    localparam words_t SEED_ZERO_WORDS = {32'h4807_7044, 32'h714A_CB41,
                                          32'h6C07_8967, 32'h0000_0001};

    function automatic logic [31:0] mix11_8(input logic [31:0] v);
        logic [31:0] t;
        t = v ^ (v << 11);
        return t ^ (t >> 8);
    endfunction

endpackage

// ===== hw/rtl/xr128_mul.sv =====
// Shared seeding multiplier: registered low word of (s ^ (s >> 30)) * MULT_K.
module xr128_mul
    import xr128_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] seed,
    output logic [31:0] prod_reg
);

    logic [31:0] operand;
    logic [31:0] product;

    assign operand = seed ^ (seed >> 30);
    assign product = operand * MULT_K;

    always_ff @(posedge clk)
    begin
        prod_reg <= product;
    end

endmodule

// ===== hw/rtl/xr128_step.sv =====
// Draw and load step: next state words and drawn value for one command.
module xr128_step
    import xr128_pkg::*;
(
    input  cmd_t        cmd,
    input  words_t      cur_words,
    input  words_t      seed_words,
    output words_t      new_words,
    output logic [63:0] value
);

    logic [31:0] first;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] n;

    always_comb
    begin
        first     = mix11_8(cur_words[0]) ^ cur_words[3];
        hi        = first ^ (cur_words[3] >> 19);
        lo        = mix11_8(cur_words[1]) ^ hi ^ (first >> 19);
        n         = hi;
        new_words = cur_words;
        value     = '0;
        case (cmd)
            CMD_DRAW32:
            begin
                new_words[0] = cur_words[1];
                new_words[1] = cur_words[2];
                new_words[2] = cur_words[3];
                new_words[3] = n;
                value        = {32'b0, n};
            end
            CMD_DRAW64:
            begin
                new_words[0] = cur_words[2];
                new_words[1] = cur_words[3];
                new_words[2] = hi;
                new_words[3] = lo;
                value        = {hi, lo};
            end
            CMD_LOAD:
            begin
                if (seed_words != '0)
                begin
                    new_words = seed_words;
                end
                else
                begin
                    new_words = SEED_ZERO_WORDS;
                end
            end
            default:
            begin
                new_words = cur_words;
            end
        endcase
    end

endmodule

// ===== hw/rtl/xorshift128_random_generator.sv =====
// Top level of the xorshift128 generator: sequencer, state words and output register.
//
// Input channel s_axis: one transfer per command. s_axis_tuser carries the
// command (0 draw 32-bit, 1 draw 64-bit, 2 seed from one word, 3 load four
// words); s_axis_tdata carries seed_a..seed_d.
// Output channel m_axis: one transfer per command, with the drawn value and
// the four state words after the command.
// Draws and direct loads go from the idle state straight to the final step;
// seeding from one word first runs the four chained multiplies, which share
// one registered multiplier, each as a multiply step and then an add step.
// A new command is taken only once the last one has passed its final step.
// s_axis_tready is high only while the sequencer is idle.
// The output register holds a result until it is taken; the next command is
// accepted meanwhile and waits in its final step until the register is free.
// Reset loads the seed-zero state words and empties the output register.
module xorshift128_random_generator
    import xr128_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // seed_a, seed_b, seed_c, seed_d, zero pad
    input  logic [1:0]   s_axis_tuser,  // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata   // random_value, state_out0..state_out3
);

    state_t       state_reg;
    state_t       state_next;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;
    words_t       words_reg;
    words_t       words_next;
    logic         m_valid_reg;
    logic         m_valid_next;
    cmd_t         cmd_reg;
    cmd_t         cmd_next;
    words_t       seeds_reg;
    words_t       seeds_next;
    logic [31:0]  s_reg;
    logic [31:0]  s_next;
    logic [191:0] out_reg;
    logic [191:0] out_next;

    logic [31:0]  prod_reg;
    logic [31:0]  seed_word;
    words_t       step_words;
    logic [63:0]  step_value;

    xr128_mul u_mul (
        .clk      (clk),
        .seed     (s_reg),
        .prod_reg (prod_reg)
    );

    xr128_step u_step (
        .cmd        (cmd_reg),
        .cur_words  (words_reg),
        .seed_words (seeds_reg),
        .new_words  (step_words),
        .value      (step_value)
    );

    assign seed_word     = prod_reg + {30'b0, cnt_reg} + 32'd1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            words_reg   <= SEED_ZERO_WORDS;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            words_reg   <= words_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        seeds_reg <= seeds_next;
        s_reg     <= s_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        words_next   = words_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        cmd_next     = cmd_reg;
        seeds_next   = seeds_reg;
        s_next       = s_reg;
        out_next     = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next   = cmd_t'(s_axis_tuser);
                    seeds_next = words_t'(s_axis_tdata[127:0]);
                    s_next     = s_axis_tdata[31:0];
                    cnt_next   = '0;
                    if (cmd_t'(s_axis_tuser) == CMD_SEED)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                words_next[cnt_reg] = seed_word;
                s_next              = seed_word;
                if (cnt_reg == 2'd3)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    words_next   = step_words;
                    out_next     = {step_words, step_value};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after an input transfer");

    a_cnt_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> (cnt_reg == 2'd0))
        else $error("seed counter not cleared outside the multiply loop");

    a_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> (words_reg != '0))
        else $error("state words reached all zero");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("output loaded outside the final step");
`endif

endmodule

// ===== test/xorshift128_random_generator_test.sv =====
// Self-checking testbench for the xorshift128 generator: command stream, state tracking, result checks.
module xorshift128_random_generator_test;
    import xr128_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 4;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [31:0] w3;
        logic [31:0] w2;
        logic [31:0] w1;
        logic [31:0] w0;
        logic [63:0] value;
    } prng_result_t;

    class state_predictor;
        words_t       words;
        prng_result_t pending_outputs[$];
        int           errors;
        int           checked;
        int           cmd_seen[4];
        int           zero_loads;

        function new();
            words      = SEED_ZERO_WORDS;
            errors     = 0;
            checked    = 0;
            zero_loads = 0;
            foreach (cmd_seen[i]) cmd_seen[i] = 0;
        endfunction

        function logic [31:0] scramble(logic [31:0] v);
            logic [31:0] t;
            t = v ^ (v << 11);
            return t ^ (t >> 8);
        endfunction

        function void note_command(cmd_t cmd, logic [31:0] a, logic [31:0] b,
                                   logic [31:0] c, logic [31:0] d);
            logic [31:0]  mid;
            logic [31:0]  hi;
            logic [31:0]  lo;
            logic [31:0]  s;
            prng_result_t r;
            r.value = '0;
            case (cmd)
                CMD_DRAW32:
                begin
                    lo = scramble(words[0]) ^ words[3] ^ (words[3] >> 19);
                    words = {lo, words[3], words[2], words[1]};
                    r.value = {32'h0, lo};
                end
                CMD_DRAW64:
                begin
                    mid = scramble(words[0]) ^ words[3];
                    hi = mid ^ (words[3] >> 19);
                    lo = scramble(words[1]) ^ hi ^ (mid >> 19);
                    words = {lo, hi, words[3], words[2]};
                    r.value = {hi, lo};
                end
                CMD_SEED:
                begin
                    s = a;
                    for (int i = 0; i < 4; i++)
                    begin
                        s = MULT_K * (s ^ (s >> 30)) + 32'(i + 1);
                        words[i] = s;
                    end
                end
                default:
                begin
                    if ((a | b | c | d) != 32'h0)
                        words = {d, c, b, a};
                    else
                    begin
                        words = SEED_ZERO_WORDS;
                        zero_loads++;
                    end
                end
            endcase
            r.w0 = words[0];
            r.w1 = words[1];
            r.w2 = words[2];
            r.w3 = words[3];
            cmd_seen[cmd]++;
            pending_outputs.push_back(r);
        endfunction

        function void compare_field(string label, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            end
        endfunction

        function void check_result(logic [191:0] data);
            prng_result_t want;
            prng_result_t got;
            got = data;
            if (pending_outputs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, data);
                return;
            end
            want = pending_outputs.pop_front();
            checked++;
            compare_field("random_value", want.value, got.value);
            compare_field("state_out0", {32'h0, want.w0}, {32'h0, got.w0});
            compare_field("state_out1", {32'h0, want.w1}, {32'h0, got.w1});
            compare_field("state_out2", {32'h0, want.w2}, {32'h0, got.w2});
            compare_field("state_out3", {32'h0, want.w3}, {32'h0, got.w3});
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;   // seed_a, seed_b, seed_c, seed_d, zero pad
    logic [1:0]   s_axis_tuser = '0;   // command
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [191:0] m_axis_tdata;        // random_value, state_out0..state_out3

    int             idle_pct = 0;
    int             stall_pct = 0;
    int             cycle_count = 0;
    state_predictor tracker = new();

    xorshift128_random_generator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata);
    end

    task automatic send_item(input cmd_t cmd, input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic [31:0] d);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {8'h00, d, c, b, a};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_command(cmd, a, b, c, d);
    endtask

    task automatic send_random_item();
        int   pick;
        cmd_t cmd;
        pick = $urandom_range(99);
        if (pick < 40)
            cmd = CMD_DRAW32;
        else if (pick < 70)
            cmd = CMD_DRAW64;
        else if (pick < 85)
            cmd = CMD_SEED;
        else
            cmd = CMD_LOAD;
        if (cmd == CMD_LOAD && $urandom_range(7) == 0)
            send_item(cmd, 32'h0, 32'h0, 32'h0, 32'h0);
        else
            send_item(cmd, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(CMD_DRAW32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_DRAW64, $urandom, $urandom, $urandom, $urandom);
        send_item(CMD_SEED,   32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_DRAW32, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(CMD_SEED,   32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        send_item(CMD_DRAW64, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(CMD_SEED,   32'h4000_0000, 32'h0, 32'h0, 32'h0);
        send_item(CMD_SEED,   32'hC000_0000, 32'h0, 32'h0, 32'h0);
        send_item(CMD_DRAW32, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(CMD_LOAD,   32'h0, 32'h0, 32'h0, 32'h0);
        send_item(CMD_DRAW64, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_LOAD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_DRAW32, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(CMD_DRAW64, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(CMD_LOAD,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(CMD_DRAW32, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(CMD_DRAW64, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(CMD_LOAD,   32'h0, 32'h0, 32'h0, 32'h1);
        send_item(CMD_DRAW32, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(CMD_DRAW64, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(CMD_LOAD,   32'h1, 32'h0, 32'h0, 32'h0);
        send_item(CMD_DRAW64, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(CMD_DRAW32, 32'h0, 32'h0, 32'h0, 32'h0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 82;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 82;
                end
                default:
                begin
                    idle_pct = 35;
                    stall_pct <= 35;
                end
            endcase
            repeat (PHASE_ITEMS) send_random_item();
        end

        s_axis_tvalid <= 1'b0;
        stall_pct <= 0;
        while (tracker.pending_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d 32-bit draws, %0d 64-bit draws, %0d single-word seeds,",
                 tracker.cmd_seen[CMD_DRAW32], tracker.cmd_seen[CMD_DRAW64],
                 tracker.cmd_seen[CMD_SEED]);
        $display("%0d direct loads (%0d all-zero); %0d results checked over four pacing modes.",
                 tracker.cmd_seen[CMD_LOAD], tracker.zero_loads, tracker.checked);
        if (tracker.errors == 0 && tracker.pending_outputs.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/xr128_pkg.sv
hw/rtl/xr128_mul.sv
hw/rtl/xr128_step.sv
hw/rtl/xorshift128_random_generator.sv
test/xorshift128_random_generator_test.sv
